FILE: hw/rtl/dms_pkg.sv
// Shared constants and helpers for the DMS sphere to Cartesian converter.
// No dependencies; used by dms_trig, dms_sphere_to_cartesian and the bench.
package dms_pkg;

  localparam int AngleFracBits = 16;
  localparam int TrigStages    = 18;

  localparam logic [20:0] SecPerQuarter = 21'd324000;
  localparam logic [20:0] SecPerTurn    = 21'd1296000;
  localparam logic [38:0] RadPerSecQ56  = 39'd349345074174;
  localparam logic [29:0] GainInvQ30    = 30'd652032874;
  localparam logic [15:0] RadiusReset   = 16'd6371;
  localparam int          OutLimit      = 16776960;

  // atan(2^-i) in Q30
  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] r;
    begin
      case (i)
        0:  r = 30'd843314857;
        1:  r = 30'd497837829;
        2:  r = 30'd263043837;
        3:  r = 30'd133525159;
        4:  r = 30'd67021687;
        5:  r = 30'd33543516;
        6:  r = 30'd16775851;
        7:  r = 30'd8388437;
        8:  r = 30'd4194283;
        9:  r = 30'd2097149;
        10: r = 30'd1048576;
        default: r = (i <= 30) ? 30'(64'd1 << (30 - i)) : 30'd0;
      endcase
      return r;
    end
  endfunction

  // round half up of a Q30 value to F fraction bits
  function automatic logic [31:0] q30_round(input logic [29:0] v, input int f);
    logic [63:0] t;
    begin
      t = ({34'd0, v} << 1) + (64'd1 << (30 - f));
      return 32'(t >> (31 - f));
    end
  endfunction

endpackage

FILE: hw/rtl/dms_trig.sv
// Pipelined cosine and sine of an angle in arc seconds (rotation CORDIC).
// Depends on dms_pkg.
module dms_trig #(
  parameter int ANGLE_FRAC_BITS = dms_pkg::AngleFracBits,
  parameter int TRIG_STAGES     = dms_pkg::TrigStages
) (
  input  logic                         clk,
  input  logic [20:0]                  secs,
  output logic signed [ANGLE_FRAC_BITS+2:0] cos_out,
  output logic signed [ANGLE_FRAC_BITS+2:0] sin_out
);
  localparam int W  = ANGLE_FRAC_BITS + 3;
  localparam int AW = ANGLE_FRAC_BITS + 3;

  // stage A: reduce modulo one turn (input < 2 turns)
  logic [20:0] red;
  always_ff @(posedge clk) begin
    red <= (secs >= dms_pkg::SecPerTurn) ? secs - dms_pkg::SecPerTurn : secs;
  end

  // stage B: quadrant split
  logic [1:0]  quad;
  logic [18:0] rest;
  always_ff @(posedge clk) begin
    if (red >= 21'd972000) begin
      quad <= 2'd3; rest <= 19'(red - 21'd972000);
    end else if (red >= 21'd648000) begin
      quad <= 2'd2; rest <= 19'(red - 21'd648000);
    end else if (red >= dms_pkg::SecPerQuarter) begin
      quad <= 2'd1; rest <= 19'(red - dms_pkg::SecPerQuarter);
    end else begin
      quad <= 2'd0; rest <= 19'(red);
    end
  end

  // stage C: to radians, rounded to F fraction bits
  logic [57:0] prod;
  logic [1:0]  quad_c;
  always_ff @(posedge clk) begin
    prod   <= {39'd0, rest} * {19'd0, dms_pkg::RadPerSecQ56};
    quad_c <= quad;
  end
  logic signed [AW-1:0] ang0;
  logic [57:0] prod_r;
  assign prod_r = prod + (58'd1 << (55 - ANGLE_FRAC_BITS));
  assign ang0 = AW'(prod_r >> (56 - ANGLE_FRAC_BITS));

  // CORDIC stages
  logic signed [W-1:0]  xs [TRIG_STAGES+1];
  logic signed [W-1:0]  ys [TRIG_STAGES+1];
  logic signed [AW-1:0] as [TRIG_STAGES+1];
  logic [1:0]           qs [TRIG_STAGES+1];
  assign xs[0] = W'(dms_pkg::q30_round(dms_pkg::GainInvQ30, ANGLE_FRAC_BITS));
  assign ys[0] = '0;
  assign as[0] = ang0;
  assign qs[0] = quad_c;

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
    localparam logic signed [AW-1:0] DA =
      AW'(dms_pkg::q30_round(dms_pkg::atan_q30(i), ANGLE_FRAC_BITS));
    logic signed [W-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (!as[i][AW-1]) begin
        xs[i+1] <= xs[i] - dx; ys[i+1] <= ys[i] + dy; as[i+1] <= as[i] - DA;
      end else begin
        xs[i+1] <= xs[i] + dx; ys[i+1] <= ys[i] - dy; as[i+1] <= as[i] + DA;
      end
      qs[i+1] <= qs[i];
    end
  end

  // quadrant fold
  logic signed [W-1:0] xf, yf;
  assign xf = xs[TRIG_STAGES];
  assign yf = ys[TRIG_STAGES];
  always_ff @(posedge clk) begin
    case (qs[TRIG_STAGES])
      2'd0:    begin cos_out <= xf;  sin_out <= yf;  end
      2'd1:    begin cos_out <= -yf; sin_out <= xf;  end
      2'd2:    begin cos_out <= -xf; sin_out <= -yf; end
      default: begin cos_out <= yf;  sin_out <= -xf; end
    endcase
  end
endmodule

FILE: hw/rtl/dms_sphere_to_cartesian.sv
// Top level of the DMS latitude/longitude to Cartesian converter.
// Depends on dms_pkg and dms_trig.
//
// Accepts one position per clock while busy is low (busy is held low: the
// pipeline never stalls). Each result appears on done for one cycle. The
// pipeline holds the CORDIC stages plus arc second formation, turn reduction,
// quadrant split, radian scaling, quadrant fold, two multiply stages and the
// rounding and saturation stage.
// The receiver cannot hold results off, so results must be taken when done
// is high.
module dms_sphere_to_cartesian #(
  parameter int ANGLE_FRAC_BITS = dms_pkg::AngleFracBits,
  parameter int TRIG_STAGES     = dms_pkg::TrigStages
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic [6:0]         lat_degrees,
  input  logic [5:0]         lat_minutes,
  input  logic [5:0]         lat_seconds,
  input  logic               lat_south,
  input  logic [7:0]         lon_degrees,
  input  logic [5:0]         lon_minutes,
  input  logic [5:0]         lon_seconds,
  input  logic               lon_west,
  output logic               done,
  output logic signed [24:0] pos_x,
  output logic signed [24:0] pos_y,
  output logic signed [24:0] pos_z
);
  localparam int W     = ANGLE_FRAC_BITS + 3;
  localparam int LAT   = TRIG_STAGES + 4;   // trig latency after seconds register
  localparam int DEPTH = LAT + 4;

  assign busy = 1'b0;

  // radius register
  logic [15:0] sphere_radius;
  always_ff @(posedge clk) begin
    if (rst) sphere_radius <= dms_pkg::RadiusReset;
    else if (cfg_we) sphere_radius <= cfg_wdata;
  end

  // valid and flag pipeline
  logic [DEPTH-1:0] vld;
  logic [1:0]       flg [DEPTH];
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[DEPTH-2:0], start};
  end
  always_ff @(posedge clk) begin
    flg[0] <= {lat_south, lon_west};
    for (int k = 1; k < DEPTH; k++) flg[k] <= flg[k-1];
  end

  // total arc seconds
  logic [20:0] lat_s, lon_s;
  always_ff @(posedge clk) begin
    lat_s <= 21'(lat_degrees * 21'd3600) + 21'(lat_minutes * 21'd60) + 21'(lat_seconds);
    lon_s <= 21'(lon_degrees * 21'd3600) + 21'(lon_minutes * 21'd60) + 21'(lon_seconds);
  end

  logic signed [W-1:0] clat, slat, clon, slon;
  dms_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TRIG_STAGES(TRIG_STAGES)) u_lat (
    .clk(clk), .secs(lat_s), .cos_out(clat), .sin_out(slat));
  dms_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TRIG_STAGES(TRIG_STAGES)) u_lon (
    .clk(clk), .secs(lon_s), .cos_out(clon), .sin_out(slon));

  // unit products
  logic signed [2*W-1:0] pcc, pcs;
  logic signed [W-1:0]   slat_d;
  always_ff @(posedge clk) begin
    pcc    <= clat * clon;
    pcs    <= clat * slon;
    slat_d <= slat;
  end
  logic signed [W-1:0] ucc, ucs;
  assign ucc = W'((pcc + $signed((2*W)'(64'd1 << (ANGLE_FRAC_BITS-1)))) >>> ANGLE_FRAC_BITS);
  assign ucs = W'((pcs + $signed((2*W)'(64'd1 << (ANGLE_FRAC_BITS-1)))) >>> ANGLE_FRAC_BITS);

  // scale by radius
  logic signed [W+16:0] rx, ry, rz;
  logic signed [16:0]   rad_s;
  assign rad_s = {1'b0, sphere_radius};
  always_ff @(posedge clk) begin
    rx <= rad_s * ucc;
    ry <= rad_s * ucs;
    rz <= rad_s * slat_d;
  end

  function automatic logic signed [24:0] finish(input logic signed [W+16:0] v,
                                                input logic neg);
    logic signed [W+17:0] r;
    begin
      r = (W+18)'((v + $signed((W+17)'(64'd1 << (ANGLE_FRAC_BITS-9))))
                  >>> (ANGLE_FRAC_BITS-8));
      if (neg) r = -r;
      if (r > (W+18)'(dms_pkg::OutLimit)) r = (W+18)'(dms_pkg::OutLimit);
      if (r < -(W+18)'(dms_pkg::OutLimit)) r = -(W+18)'(dms_pkg::OutLimit);
      return 25'(r);
    end
  endfunction

  always_ff @(posedge clk) begin
    pos_x <= finish(rx, 1'b0);
    pos_y <= finish(ry, flg[DEPTH-2][0]);
    pos_z <= finish(rz, flg[DEPTH-2][1]);
  end
  assign done = vld[DEPTH-1];

  // each start leads to a result beat on done at the end of the valid pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(DEPTH) (done || $past(rst, DEPTH))) else $error("lost result");
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    done |-> (pos_x <= 25'sd16776960 && pos_x >= -25'sd16776960)) else $error("x range");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule

FILE: sim/tb.sv
// Self-checking bench for dms_sphere_to_cartesian: drives positions, predicts x/y/z.
// Depends on dms_pkg for its constants and on the top level RTL.
`timescale 1ns / 1ps

// Holds predicted coordinates and checks each result beat against the oldest one
class position_scoreboard;
  localparam int FRAC = dms_pkg::AngleFracBits;
  localparam int STAGES = dms_pkg::TrigStages;

  typedef struct {
    logic signed [24:0] x;
    logic signed [24:0] y;
    logic signed [24:0] z;
  } coord_t;

  coord_t pending[$];
  int errors = 0;

  // Q30 arctangent values of 2^-i for the first stages
  longint atan_head[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149, 1048576};

  function longint q30_to_frac(longint q);
    return (2 * q + (longint'(1) << (30 - FRAC))) >>> (31 - FRAC);
  endfunction

  function longint round_down_bits(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  // rotation CORDIC on the angle in arc seconds, quadrant applied afterwards
  function void trig_of_secs(longint unsigned secs, output longint c, output longint s);
    longint unsigned t, rest, p;
    int quad;
    longint ang, cx, cy, dx, dy, da;
    t = secs % 1296000;
    quad = int'(t / 324000);
    rest = t - longint'(quad) * 324000;
    p = rest * 64'd349345074174 + (64'd1 << (55 - FRAC));
    ang = longint'(p >> (56 - FRAC));
    cx = q30_to_frac(longint'(dms_pkg::GainInvQ30));
    cy = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (i <= 10) da = q30_to_frac(atan_head[i]);
      else if (i <= 30) da = q30_to_frac(longint'(1) << (30 - i));
      else da = 0;
      if (ang >= 0) begin
        cx -= dx; cy += dy; ang -= da;
      end else begin
        cx += dx; cy -= dy; ang += da;
      end
    end
    case (quad)
      0: begin c = cx; s = cy; end
      1: begin c = -cy; s = cx; end
      2: begin c = -cx; s = -cy; end
      default: begin c = cy; s = -cx; end
    endcase
  endfunction

  function logic [24:0] scale_coord(longint u, bit neg, int unsigned radius);
    longint v;
    v = round_down_bits(longint'(radius) * u, FRAC - 8);
    if (neg) v = -v;
    if (v > dms_pkg::OutLimit) v = dms_pkg::OutLimit;
    if (v < -dms_pkg::OutLimit) v = -dms_pkg::OutLimit;
    return v[24:0];
  endfunction

  // an accepted input beat: work out its coordinates
  function void note_position(logic [6:0] lat_d, logic [5:0] lat_m, logic [5:0] lat_s,
                              bit south, logic [7:0] lon_d, logic [5:0] lon_m,
                              logic [5:0] lon_s, bit west, int unsigned radius);
    longint clat, slat, clon, slon;
    coord_t e;
    trig_of_secs(longint'(lat_d) * 3600 + longint'(lat_m) * 60 + lat_s, clat, slat);
    trig_of_secs(longint'(lon_d) * 3600 + longint'(lon_m) * 60 + lon_s, clon, slon);
    e.x = scale_coord(round_down_bits(clat * clon, FRAC), 1'b0, radius);
    e.y = scale_coord(round_down_bits(clat * slon, FRAC), west, radius);
    e.z = scale_coord(slat, south, radius);
    pending.push_back(e);
  endfunction

  function void check_coord(logic signed [24:0] x, logic signed [24:0] y,
                            logic signed [24:0] z);
    coord_t e;
    if (pending.size() == 0) begin
      $error("result beat with nothing expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (x !== e.x) begin $error("pos_x expected %0d got %0d", e.x, x); errors++; end
    if (y !== e.y) begin $error("pos_y expected %0d got %0d", e.y, y); errors++; end
    if (z !== e.z) begin $error("pos_z expected %0d got %0d", e.z, z); errors++; end
  endfunction
endclass

module tb;
  localparam int LATENCY = dms_pkg::TrigStages + 8;
  localparam int STALL_LIMIT = 5000;

  logic clk, rst, start, busy, cfg_we, done;
  logic [15:0] cfg_wdata;
  logic [6:0] lat_degrees;
  logic [5:0] lat_minutes, lat_seconds, lon_minutes, lon_seconds;
  logic [7:0] lon_degrees;
  logic lat_south, lon_west;
  logic signed [24:0] pos_x, pos_y, pos_z;

  position_scoreboard sb = new();
  int unsigned radius_now = dms_pkg::RadiusReset;
  int stall_cnt;
  bit allow_gaps;

  dms_sphere_to_cartesian u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .lat_degrees(lat_degrees), .lat_minutes(lat_minutes), .lat_seconds(lat_seconds),
    .lat_south(lat_south), .lon_degrees(lon_degrees), .lon_minutes(lon_minutes),
    .lon_seconds(lon_seconds), .lon_west(lon_west),
    .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitor: input beats and result beats sampled at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        sb.note_position(lat_degrees, lat_minutes, lat_seconds, lat_south,
                         lon_degrees, lon_minutes, lon_seconds, lon_west, radius_now);
      if (done) sb.check_coord(pos_x, pos_y, pos_z);
    end
  end

  // watchdog on cycles with no beat at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_position(int ld, int lm, int ls, bit so, int od, int om, int os,
                               bit we);
    if (allow_gaps && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start <= 1'b1;
    lat_degrees <= 7'(ld); lat_minutes <= 6'(lm); lat_seconds <= 6'(ls); lat_south <= so;
    lon_degrees <= 8'(od); lon_minutes <= 6'(om); lon_seconds <= 6'(os); lon_west <= we;
    do @(posedge clk); while (busy);
  endtask

  // pick a field value: mostly in range, sometimes anywhere in the port width
  function automatic int pick(int hi, int width);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, (1 << width) - 1);
    return $urandom_range(0, hi);
  endfunction

  task automatic send_random(int n);
    repeat (n)
      send_position(pick(90, 7), pick(59, 6), pick(59, 6), 1'($urandom_range(0, 1)),
                    pick(180, 8), pick(59, 6), pick(59, 6), 1'($urandom_range(0, 1)));
  endtask

  // drain the pipeline, then write the radius
  task automatic set_radius(int unsigned r);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= r[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_now = r;
  endtask

  initial begin
    rst <= 1'b1; start <= 1'b0; cfg_we <= 1'b0; cfg_wdata <= '0;
    lat_degrees <= '0; lat_minutes <= '0; lat_seconds <= '0; lat_south <= 1'b0;
    lon_degrees <= '0; lon_minutes <= '0; lon_seconds <= '0; lon_west <= 1'b0;
    allow_gaps = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beats on the reset radius: poles, antimeridian, hemispheres, full width
    send_position(0, 0, 0, 0, 0, 0, 0, 0);
    send_position(90, 0, 0, 0, 0, 0, 0, 0);
    send_position(90, 0, 0, 1, 0, 0, 0, 1);
    send_position(0, 0, 0, 0, 180, 0, 0, 0);
    send_position(0, 0, 0, 0, 90, 0, 0, 1);
    send_position(45, 30, 30, 1, 45, 30, 30, 1);
    send_position(89, 59, 59, 0, 179, 59, 59, 1);
    send_position(127, 63, 63, 1, 255, 63, 63, 1);
    send_position(120, 0, 0, 0, 200, 0, 0, 0);
    send_position(0, 0, 1, 0, 0, 0, 1, 0);
    send_random(90);

    // largest radius drives the coordinates to the saturation limit
    set_radius(65535);
    send_position(0, 0, 0, 0, 0, 0, 0, 0);
    send_position(90, 0, 0, 1, 0, 0, 0, 0);
    send_position(0, 0, 0, 0, 90, 0, 0, 1);
    send_random(100);

    set_radius(1);
    send_random(100);

    // zero radius: every coordinate is zero
    set_radius(0);
    send_position(45, 0, 0, 1, 45, 0, 0, 1);
    send_random(40);

    set_radius($urandom_range(1, 65535));
    send_random(100);

    set_radius(6371);
    send_random(50);
    allow_gaps = 1'b0;
    send_random(100);
    start <= 1'b0;

    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/dms_pkg.sv
hw/rtl/dms_trig.sv
hw/rtl/dms_sphere_to_cartesian.sv
sim/tb.sv
